// ===== rtl/core/swco_pkg.sv =====
// Types and constants shared by the swept-circle overlap test core.
`timescale 1ns / 1ps
package swco_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned OpW    = ProdW + 1;
  localparam int unsigned DigW   = 23;
  localparam int unsigned NDig   = 3;
  localparam int unsigned PadW   = DigW * NDig;
  localparam int unsigned AccW   = 2 * PadW;
  localparam int unsigned NCell  = NDig * NDig;

  typedef struct packed {
    logic decided;
    logic dval;
    logic p_le;
  } swco_flag_t;

  typedef struct packed {
    logic             vld;
    swco_flag_t       flg;
    logic [OpW-1:0]   r2;
    logic [OpW-1:0]   len2;
    logic [OpW-1:0]   crm;
    logic [OpW-1:0]   q;
    logic [AccW-1:0]  lhs;
    logic [AccW-1:0]  c2;
    logic [AccW-1:0]  qq;
  } swco_chain_t;

endpackage

// ===== rtl/core/swept_circle_overlap_test_unit.sv =====
// Top level of the swept-circle overlap test: front-end stages, product chain, decision.
`timescale 1ns / 1ps
// Takes one circle pair per cycle while not held and returns one hit word per pair, in order:
// four front-end stages form the differences, 33x33 products, sums and the root-sign
// tests, a chain of nine cells builds the three exact 138-bit products one 23x23 digit
// pair per cell, and two stages compare them. The whole pipeline holds while a finished
// word waits on out_ready_i; a word is accepted whenever the output register is empty or
// being taken.
module swept_circle_overlap_test_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [swco_pkg::CoordW-1:0] start_x_i,
  input  logic [swco_pkg::CoordW-1:0] start_y_i,
  input  logic [swco_pkg::CoordW-1:0] end_x_i,
  input  logic [swco_pkg::CoordW-1:0] end_y_i,
  input  logic [swco_pkg::CoordW-1:0] target_x_i,
  input  logic [swco_pkg::CoordW-1:0] target_y_i,
  input  logic [swco_pkg::RadW-1:0]   mover_radius_i,
  input  logic [swco_pkg::RadW-1:0]   target_radius_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o
);
  import swco_pkg::*;

  logic en;

  logic                     s1_vld_q;
  logic signed [DiffW-1:0]  ax_q, ay_q, dx_q, dy_q, ax_d, ay_d, dx_d, dy_d;
  logic [CoordW-1:0]        rad_q, rad_d;

  logic                     s2_vld_q;
  logic signed [ProdW-1:0]  sqax_q, sqay_q, sqdx_q, sqdy_q, axdx_q, aydy_q, axdy_q, aydx_q;
  logic [2*CoordW-1:0]      r2s_q;

  logic                     s3_vld_q;
  logic [OpW-1:0]           a2_q, len2_q, dot_q, cr_q;
  logic [2*CoordW-1:0]      r2t_q;

  swco_chain_t              chain [NCell+1];
  swco_chain_t              c0_d, c0_q;
  logic [OpW-1:0]           p_d;

  logic                     f1_vld_q, f1_ge_q;
  swco_flag_t               f1_flg_q;
  logic [AccW-1:0]          f1_disc_q, f1_qq_q;

  logic                     out_vld_q, hit_q, hit_d;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign ax_d  = {start_x_i[CoordW-1], start_x_i} - {target_x_i[CoordW-1], target_x_i};
  assign ay_d  = {start_y_i[CoordW-1], start_y_i} - {target_y_i[CoordW-1], target_y_i};
  assign dx_d  = {end_x_i[CoordW-1], end_x_i} - {start_x_i[CoordW-1], start_x_i};
  assign dy_d  = {end_y_i[CoordW-1], end_y_i} - {start_y_i[CoordW-1], start_y_i};
  assign rad_d = CoordW'(mover_radius_i) + CoordW'(target_radius_i);

  always_comb begin
    p_d            = OpW'(0) - dot_q;
    c0_d.vld       = s3_vld_q;
    c0_d.flg.dval  = ({3'b000, r2t_q} >= a2_q);
    c0_d.flg.decided = c0_d.flg.dval || (len2_q == '0) || !dot_q[OpW-1];
    c0_d.flg.p_le  = (p_d <= len2_q);
    c0_d.r2        = OpW'(r2t_q);
    c0_d.len2      = len2_q;
    c0_d.crm       = cr_q[OpW-1] ? (OpW'(0) - cr_q) : cr_q;
    c0_d.q         = p_d - len2_q;
    c0_d.lhs       = '0;
    c0_d.c2        = '0;
    c0_d.qq        = '0;
  end

  assign chain[0] = c0_q;

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    swco_mul_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (chain[k]),
      .out_o  (chain[k+1])
    );
  end

  assign hit_d = f1_flg_q.decided ? f1_flg_q.dval
                                  : (f1_ge_q && (f1_flg_q.p_le || (f1_qq_q <= f1_disc_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      c0_q      <= '0;
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      c0_q      <= c0_d;
      f1_vld_q  <= chain[NCell].vld;
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      rad_q  <= rad_d;
      sqax_q <= ax_q * ax_q;
      sqay_q <= ay_q * ay_q;
      sqdx_q <= dx_q * dx_q;
      sqdy_q <= dy_q * dy_q;
      axdx_q <= ax_q * dx_q;
      aydy_q <= ay_q * dy_q;
      axdy_q <= ax_q * dy_q;
      aydx_q <= ay_q * dx_q;
      r2s_q  <= rad_q * rad_q;
      a2_q   <= {1'b0, sqax_q} + {1'b0, sqay_q};
      len2_q <= {1'b0, sqdx_q} + {1'b0, sqdy_q};
      dot_q  <= {axdx_q[ProdW-1], axdx_q} + {aydy_q[ProdW-1], aydy_q};
      cr_q   <= {axdy_q[ProdW-1], axdy_q} - {aydx_q[ProdW-1], aydx_q};
      r2t_q  <= r2s_q;
      f1_flg_q  <= chain[NCell].flg;
      f1_ge_q   <= (chain[NCell].lhs >= chain[NCell].c2);
      f1_disc_q <= chain[NCell].lhs - chain[NCell].c2;
      f1_qq_q   <= chain[NCell].qq;
      hit_q     <= hit_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;

  a_decided_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && f1_vld_q && f1_flg_q.decided) |=> (hit_o == $past(f1_flg_q.dval)))
    else $error("decided result lost in final stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_vld_q)
    else $error("accepted word missing from first stage");

  a_inside_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c0_q.vld && c0_q.flg.dval) |-> c0_q.flg.decided)
    else $error("start inside radius not marked decided");

endmodule

// ===== rtl/core/swco_mul_cell.sv =====
// One cell of the product chain: adds one digit-pair partial product to each accumulator.
`timescale 1ns / 1ps
module swco_mul_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  swco_pkg::swco_chain_t in_i,
  output swco_pkg::swco_chain_t out_o
);
  import swco_pkg::*;

  localparam int unsigned DI = Idx / NDig;
  localparam int unsigned DJ = Idx % NDig;
  localparam int unsigned Sh = (DI + DJ) * DigW;

  logic [PadW-1:0]   r2_p, len2_p, crm_p, q_p;
  logic [2*DigW-1:0] pp_lhs, pp_c2, pp_qq;
  swco_chain_t       out_d, out_q;

  assign r2_p   = PadW'(in_i.r2);
  assign len2_p = PadW'(in_i.len2);
  assign crm_p  = PadW'(in_i.crm);
  assign q_p    = PadW'(in_i.q);

  assign pp_lhs = r2_p[DI*DigW +: DigW] * len2_p[DJ*DigW +: DigW];
  assign pp_c2  = crm_p[DI*DigW +: DigW] * crm_p[DJ*DigW +: DigW];
  assign pp_qq  = q_p[DI*DigW +: DigW] * q_p[DJ*DigW +: DigW];

  always_comb begin
    out_d     = in_i;
    out_d.lhs = in_i.lhs + (AccW'(pp_lhs) << Sh);
    out_d.c2  = in_i.c2 + (AccW'(pp_c2) << Sh);
    out_d.qq  = in_i.qq + (AccW'(pp_qq) << Sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== verif/swco_checker.sv =====
// Checker for the swept-circle overlap test: predicts the hit word per pair and compares.
`timescale 1ns / 1ps
module swco_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [swco_pkg::CoordW-1:0] start_x_i,
  input  logic [swco_pkg::CoordW-1:0] start_y_i,
  input  logic [swco_pkg::CoordW-1:0] end_x_i,
  input  logic [swco_pkg::CoordW-1:0] end_y_i,
  input  logic [swco_pkg::CoordW-1:0] target_x_i,
  input  logic [swco_pkg::CoordW-1:0] target_y_i,
  input  logic [swco_pkg::RadW-1:0]   mover_radius_i,
  input  logic [swco_pkg::RadW-1:0]   target_radius_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        hit_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          hits_seen_o
);

  typedef logic signed [199:0] wint_t;

  bit hit_queue[$];

  function automatic bit predict_hit(
    logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey,
    logic [31:0] tx, logic [31:0] ty, logic [30:0] mr, logic [30:0] tr);
    wint_t ax, ay, dx, dy, rad, r2, a2, len2, p, cr, lhs, c2, disc, q;
    ax   = wint_t'($signed(sx)) - wint_t'($signed(tx));
    ay   = wint_t'($signed(sy)) - wint_t'($signed(ty));
    dx   = wint_t'($signed(ex)) - wint_t'($signed(sx));
    dy   = wint_t'($signed(ey)) - wint_t'($signed(sy));
    rad  = wint_t'(mr) + wint_t'(tr);
    r2   = rad * rad;
    a2   = ax * ax + ay * ay;
    if (a2 <= r2) return 1'b1;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return 1'b0;
    p = -(ax * dx + ay * dy);
    if (p <= 0) return 1'b0;
    cr   = ax * dy - ay * dx;
    lhs  = r2 * len2;
    c2   = cr * cr;
    if (lhs < c2) return 1'b0;
    disc = lhs - c2;
    if (p <= len2) return 1'b1;
    q = p - len2;
    return (q * q) <= disc;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      hits_seen_o  <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        hit_queue.push_back(predict_hit(start_x_i, start_y_i, end_x_i, end_y_i,
                                        target_x_i, target_y_i, mover_radius_i,
                                        target_radius_i));
      if (out_valid_i && out_ready_i) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual hit=%0b", $time, hit_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          bit want;
          want = hit_queue.pop_front();
          if (want !== hit_i) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, hit_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (hit_i) hits_seen_o <= hits_seen_o + 1;
        end
      end
      pending_o <= hit_queue.size();
    end
  end

endmodule

// ===== verif/tb_swept_circle_overlap_test_unit.sv =====
// Testbench top for the swept-circle overlap test: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_swept_circle_overlap_test_unit;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready, hit;
  logic [31:0] sx, sy, ex, ey, tx, ty;
  logic [30:0] mr, tr;
  int          fails, pending, hits_seen, sent, send_idle, recv_idle;

  swept_circle_overlap_test_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .target_x_i(tx), .target_y_i(ty), .mover_radius_i(mr), .target_radius_i(tr),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .hit_o(hit)
  );

  swco_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .target_x_i(tx), .target_y_i(ty), .mover_radius_i(mr), .target_radius_i(tr),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .hit_i(hit),
    .fail_count_o(fails), .pending_o(pending), .hits_seen_o(hits_seen)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk)
    out_ready <= !rst_n ? 1'b0 : ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(40000)) - 20000) <<< $urandom_range(4, 16);
      default: return 32'($signed($urandom_range(400)) - 200) <<< 16;
    endcase
  endfunction

  task automatic send_pair(logic [31:0] a, b, c, d, e, f, logic [30:0] g, h);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    sx <= a; sy <= b; ex <= c; ey <= d; tx <= e; ty <= f; mr <= g; tr <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    int          mode;
    logic [31:0] a, b;
    logic [30:0] r;
    mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
    a = rand_coord(mode);
    b = rand_coord(mode);
    r = mode == 0 ? 31'($urandom()) : 31'($urandom_range(60)) << $urandom_range(8, 16);
    if ($urandom_range(9) == 0)
      send_pair(a, b, a, b, rand_coord(mode), rand_coord(mode), r, r >> 1);
    else
      send_pair(a, b, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                rand_coord(mode), r, 31'($urandom_range(60)) << $urandom_range(4, 16));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] MaxC = 32'h7fff_ffff;
  localparam logic [31:0] MinC = 32'h8000_0000;
  localparam logic [30:0] MaxR = 31'h7fff_ffff;

  initial begin
    in_valid = 1'b0; sent = 0;
    sx = '0; sy = '0; ex = '0; ey = '0; tx = '0; ty = '0; mr = '0; tr = '0;
    send_idle = 18; recv_idle = 65;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // start on boundary, inside, tangent path, zero-length outside, target behind, beyond
    send_pair(3 * One, 0, 9 * One, 0, 0, 0, 31'(2 * One), 31'(One));
    send_pair(0, 0, 0, 0, 0, 0, '0, '0);
    send_pair(-5 * One, One, 5 * One, One, 0, 0, 31'(One), '0);
    send_pair(-5 * One, 0, -5 * One, 0, 0, 0, 31'(One), 31'(One));
    send_pair(-5 * One, 0, -9 * One, 0, 0, 0, 31'(One), 31'(One));
    send_pair(-9 * One, 0, -5 * One, 0, 0, 0, 31'(One), 31'(One));
    send_pair(-5 * One, 0, -2 * One, 0, 0, 0, 31'(One), 31'(One));
    send_pair(-5 * One, 0, 5 * One, 0, 0, 0, 31'(One), 31'(One));
    send_pair(-5 * One, 2 * One, 5 * One, 2 * One, 0, 0, 31'(One), 31'(One) - 1);
    send_pair(MinC, MinC, MaxC, MaxC, MaxC, MinC, MaxR, MaxR);
    send_pair(MinC, MinC, MaxC, MaxC, MaxC, MinC, '0, '0);
    send_pair(MaxC, MaxC, MinC, MinC, MinC, MaxC, 31'h1, '0);
    send_pair(MinC, MinC, MinC, MinC, MaxC, MaxC, MaxR, MaxR);
    send_pair(MaxC, MinC, MinC, MaxC, MaxC, MaxC, MaxR, '0);
    send_pair('1, '1, '1, '1, '1, '1, MaxR, MaxR);
    drain();
    repeat (20) @(negedge clk);
    repeat (500) send_random();
    drain();
    send_idle = 65; recv_idle = 18;
    repeat (500) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (500) send_random();
    drain();
    repeat (30) @(negedge clk);
    $display("Sent %0d circle pairs over three idling phases; %0d hit words observed.",
             sent, hits_seen);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
